// File: hw/rtl/tcw_pkg.sv
// types, constants and address helper shared by the text console writer
package tcw_pkg;

  // screen geometry
  localparam int SCREEN_COLS = 80;
  localparam int SCREEN_ROWS = 25;
  localparam int CELLS       = SCREEN_COLS * SCREEN_ROWS;
  localparam int ADDR_W      = $clog2(CELLS);

  // field widths
  localparam int CHAR_W = 8;
  localparam int ROW_W  = 5;
  localparam int COL_W  = 7;

  // stream widths, padded to whole bytes
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 24;

  // character codes with a meaning of their own
  localparam logic [CHAR_W-1:0] CHAR_NULL    = 8'd0;
  localparam logic [CHAR_W-1:0] CHAR_NEWLINE = 8'd10;

  typedef enum logic {
    OP_PUT  = 1'b0,
    OP_READ = 1'b1
  } op_e;

  typedef struct packed {
    op_e               opcode;
    logic [CHAR_W-1:0] char_code;
    logic [ROW_W-1:0]  read_row;
    logic [COL_W-1:0]  read_col;
  } item_t;

  typedef struct packed {
    logic [CHAR_W-1:0] read_char;
    logic [ROW_W-1:0]  cur_row;
    logic [COL_W-1:0]  cur_col;
    logic              scrolled;
  } result_t;

  // one write and one read port of the screen store
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [CHAR_W-1:0] wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

  // controller status towards the stream stages
  typedef struct packed {
    logic clearing;
    logic consume;
    logic res_load;
  } ctrl_status_t;

  // physical cell address: rows form a ring that starts at base
  function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] base,
                                                  input logic [ROW_W-1:0] row,
                                                  input logic [COL_W-1:0] col);
    logic [ROW_W:0] phys;
    phys = {1'b0, base} + {1'b0, row};
    if (phys >= (ROW_W + 1)'(SCREEN_ROWS)) begin
      phys = phys - (ROW_W + 1)'(SCREEN_ROWS);
    end
    return ADDR_W'(phys) * ADDR_W'(SCREEN_COLS) + ADDR_W'(col);
  endfunction

endpackage

// File: hw/rtl/tcw_screen_ram.sv
// screen character store: one write port, one registered read port
module tcw_screen_ram (
  input  logic                          clk_i,
  input  tcw_pkg::mem_req_t             req_i,
  output logic [tcw_pkg::CHAR_W-1:0]    rdata_o
);

  logic [tcw_pkg::CHAR_W-1:0] mem_q [tcw_pkg::CELLS];
  logic [tcw_pkg::CHAR_W-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
  end

  // read port, registered
  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rdata_q <= mem_q[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hw/rtl/tcw_ctrl.sv
// cursor, row ring base and sequencer for puts, reads, scrolls and clearing
module tcw_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          item_valid_i,
  input  tcw_pkg::item_t                item_i,
  input  logic                          out_free_i,
  input  logic [tcw_pkg::CHAR_W-1:0]    rdata_i,
  output tcw_pkg::mem_req_t             mem_req_o,
  output tcw_pkg::result_t              result_o,
  output tcw_pkg::ctrl_status_t         status_o
);

  typedef enum logic [4:0] {
    ST_CLEAR  = 5'b00001,
    ST_IDLE   = 5'b00010,
    ST_RDWAIT = 5'b00100,
    ST_COPY   = 5'b01000,
    ST_WRAP   = 5'b10000
  } state_e;

  localparam logic [tcw_pkg::ROW_W-1:0] LAST_ROW = tcw_pkg::ROW_W'(tcw_pkg::SCREEN_ROWS - 1);
  localparam logic [tcw_pkg::COL_W-1:0] NUM_COLS = tcw_pkg::COL_W'(tcw_pkg::SCREEN_COLS);
  localparam logic [tcw_pkg::ROW_W-1:0] NUM_ROWS = tcw_pkg::ROW_W'(tcw_pkg::SCREEN_ROWS);
  localparam logic [tcw_pkg::ADDR_W-1:0] LAST_CELL = tcw_pkg::ADDR_W'(tcw_pkg::CELLS - 1);

  state_e                      state_q, state_d;
  logic [tcw_pkg::ROW_W-1:0]   row_q, row_d;
  logic [tcw_pkg::COL_W-1:0]   col_q, col_d;
  logic [tcw_pkg::ROW_W-1:0]   base_q, base_d;
  logic [tcw_pkg::ADDR_W-1:0]  cnt_q, cnt_d;
  logic                        rd_ok_q, rd_ok_d;
  logic                        rd_ok;
  logic [tcw_pkg::COL_W-1:0]   copy_col;

  assign rd_ok    = (item_i.read_row < NUM_ROWS) && (item_i.read_col < NUM_COLS);
  assign copy_col = cnt_q[tcw_pkg::COL_W-1:0];

  // sequencer
  always_comb begin
    state_d   = state_q;
    row_d     = row_q;
    col_d     = col_q;
    base_d    = base_q;
    cnt_d     = cnt_q;
    rd_ok_d   = rd_ok_q;
    mem_req_o = '0;
    status_o  = '0;
    result_o.read_char = '0;
    result_o.scrolled  = 1'b0;

    unique case (state_q)
      // zero every cell after reset
      ST_CLEAR: begin
        status_o.clearing = 1'b1;
        mem_req_o.we      = 1'b1;
        mem_req_o.waddr   = cnt_q;
        mem_req_o.wdata   = '0;
        cnt_d             = cnt_q + 1'b1;
        if (cnt_q == LAST_CELL) begin
          cnt_d   = '0;
          state_d = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (item_valid_i && out_free_i) begin
          if (item_i.opcode == tcw_pkg::OP_READ) begin
            mem_req_o.re     = rd_ok;
            mem_req_o.raddr  = tcw_pkg::cell_addr(base_q, item_i.read_row, item_i.read_col);
            rd_ok_d          = rd_ok;
            status_o.consume = 1'b1;
            state_d          = ST_RDWAIT;
          end else if (item_i.char_code == tcw_pkg::CHAR_NULL) begin
            status_o.consume  = 1'b1;
            status_o.res_load = 1'b1;
          end else if (item_i.char_code == tcw_pkg::CHAR_NEWLINE) begin
            if (row_q == LAST_ROW) begin
              cnt_d   = '0;
              state_d = ST_COPY;
            end else begin
              row_d             = row_q + 1'b1;
              col_d             = '0;
              status_o.consume  = 1'b1;
              status_o.res_load = 1'b1;
            end
          end else if (col_q >= NUM_COLS) begin
            // pending wrap: move to a new row first
            if (row_q == LAST_ROW) begin
              cnt_d   = '0;
              state_d = ST_COPY;
            end else begin
              mem_req_o.we      = 1'b1;
              mem_req_o.waddr   = tcw_pkg::cell_addr(base_q, row_q + 1'b1, '0);
              mem_req_o.wdata   = item_i.char_code;
              row_d             = row_q + 1'b1;
              col_d             = tcw_pkg::COL_W'(1);
              status_o.consume  = 1'b1;
              status_o.res_load = 1'b1;
            end
          end else begin
            mem_req_o.we      = 1'b1;
            mem_req_o.waddr   = tcw_pkg::cell_addr(base_q, row_q, col_q);
            mem_req_o.wdata   = item_i.char_code;
            col_d             = col_q + 1'b1;
            status_o.consume  = 1'b1;
            status_o.res_load = 1'b1;
          end
        end
      end

      // read data arrives in the cycle after the request
      ST_RDWAIT: begin
        result_o.read_char = rd_ok_q ? rdata_i : '0;
        status_o.res_load  = 1'b1;
        state_d            = ST_IDLE;
      end

      // scroll: copy the bottom row over the top row, then rotate the ring
      ST_COPY: begin
        if (copy_col < NUM_COLS) begin
          mem_req_o.re    = 1'b1;
          mem_req_o.raddr = tcw_pkg::cell_addr(base_q, LAST_ROW, copy_col);
        end
        if (cnt_q != '0) begin
          mem_req_o.we    = 1'b1;
          mem_req_o.waddr = tcw_pkg::cell_addr(base_q, '0, copy_col - 1'b1);
          mem_req_o.wdata = rdata_i;
        end
        cnt_d = cnt_q + 1'b1;
        if (copy_col == NUM_COLS) begin
          cnt_d  = '0;
          base_d = (base_q == LAST_ROW) ? '0 : base_q + 1'b1;
          if (item_i.char_code == tcw_pkg::CHAR_NEWLINE) begin
            col_d             = '0;
            result_o.scrolled = 1'b1;
            status_o.consume  = 1'b1;
            status_o.res_load = 1'b1;
            state_d           = ST_IDLE;
          end else begin
            state_d = ST_WRAP;
          end
        end
      end

      // character that caused the scroll lands at the start of the bottom row
      ST_WRAP: begin
        mem_req_o.we      = 1'b1;
        mem_req_o.waddr   = tcw_pkg::cell_addr(base_q, LAST_ROW, '0);
        mem_req_o.wdata   = item_i.char_code;
        col_d             = tcw_pkg::COL_W'(1);
        result_o.scrolled = 1'b1;
        status_o.consume  = 1'b1;
        status_o.res_load = 1'b1;
        state_d           = ST_IDLE;
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase

    result_o.cur_row = row_d;
    result_o.cur_col = col_d;
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      row_q   <= '0;
      col_q   <= '0;
      base_q  <= '0;
      cnt_q   <= '0;
      rd_ok_q <= 1'b0;
    end else begin
      state_q <= state_d;
      row_q   <= row_d;
      col_q   <= col_d;
      base_q  <= base_d;
      cnt_q   <= cnt_d;
      rd_ok_q <= rd_ok_d;
    end
  end

endmodule

// File: hw/rtl/text_console_writer.sv
// top level of the text console writer: stream stages around controller and store
//
// An 80x25 character screen with a cursor. A put transaction writes its character
// at the cursor (newline moves to the next row, code zero is ignored, column 80
// means a wrap is pending); a read transaction returns one cell. Every input
// transaction gives exactly one result transaction carrying the cursor after it.
// A put or newline that does not scroll is handled in the idle state; a read also
// waits in a read-wait state for the registered read of the screen store. An item
// that scrolls first copies the bottom row over the top row through the store's
// single read and single write port, 80 cells, and a character then lands in a
// wrap state, while the row order itself rotates with a base pointer at no cost.
// After reset all 2000 cells of the store are zeroed, during which s_axis_tready
// stays low. The input transaction is buffered, so one can be accepted while a
// result is still waiting on the output.
module text_console_writer (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // char_code[7:0], read_row[12:8], read_col[19:13], zero fill
  input  logic [tcw_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  // opcode[0]
  input  logic                              s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // read_char[7:0], cur_row[12:8], cur_col[19:13], scrolled[20], zero fill
  output logic [tcw_pkg::OUT_DATA_W-1:0]    m_axis_tdata
);

  tcw_pkg::item_t         in_item;
  tcw_pkg::item_t         buf_q;
  logic                   buf_valid_q;
  tcw_pkg::result_t       res_d;
  tcw_pkg::result_t       res_q;
  logic                   m_valid_q;
  logic                   out_free;
  tcw_pkg::mem_req_t      mem_req;
  logic [tcw_pkg::CHAR_W-1:0] rdata;
  tcw_pkg::ctrl_status_t  status;

  // unpack the input transaction
  assign in_item.opcode    = tcw_pkg::op_e'(s_axis_tuser);
  assign in_item.char_code = s_axis_tdata[7:0];
  assign in_item.read_row  = s_axis_tdata[12:8];
  assign in_item.read_col  = s_axis_tdata[19:13];

  assign s_axis_tready = !status.clearing && (!buf_valid_q || status.consume);
  assign out_free      = !m_valid_q || m_axis_tready;

  // input buffer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buf_valid_q <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      buf_valid_q <= 1'b1;
    end else if (status.consume) begin
      buf_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      buf_q <= in_item;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (status.res_load) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (status.res_load) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {3'b000, res_q.scrolled, res_q.cur_col, res_q.cur_row,
                          res_q.read_char};

  // sequencer and screen store
  tcw_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (buf_valid_q),
    .item_i       (buf_q),
    .out_free_i   (out_free),
    .rdata_i      (rdata),
    .mem_req_o    (mem_req),
    .result_o     (res_d),
    .status_o     (status)
  );

  tcw_screen_ram u_ram (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (rdata)
  );

endmodule

// File: verif/tcw_checker.sv
// checker for the text console writer: watches both streams, predicts and compares results
`timescale 1ns / 1ps

module tcw_checker
  import tcw_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_tvalid_i,
  input  logic                  s_tready_i,
  // char_code[7:0], read_row[12:8], read_col[19:13], zero fill
  input  logic [IN_DATA_W-1:0]  s_tdata_i,
  // opcode[0]
  input  logic                  s_tuser_i,
  input  logic                  m_tvalid_i,
  input  logic                  m_tready_i,
  // read_char[7:0], cur_row[12:8], cur_col[19:13], scrolled[20], zero fill
  input  logic [OUT_DATA_W-1:0] m_tdata_i,
  output int                    outstanding_o,
  output int                    fail_count_o,
  output int                    scroll_count_o
);

  // screen image and cursor as the block should hold them
  logic [CHAR_W-1:0] screen_q [SCREEN_ROWS][SCREEN_COLS];
  logic [ROW_W-1:0]  cursor_row_q;
  logic [COL_W-1:0]  cursor_col_q;

  // cursor reports still owed by the block, oldest first
  result_t awaited_reports_q [$];

  // move to column 0 of the next row, shifting the screen up past the bottom row
  function automatic logic line_feed();
    cursor_col_q = '0;
    if (cursor_row_q + 1 >= SCREEN_ROWS) begin
      // bottom row keeps its old contents
      for (int r = 0; r < SCREEN_ROWS - 1; r++) begin
        for (int c = 0; c < SCREEN_COLS; c++) begin
          screen_q[r][c] = screen_q[r + 1][c];
        end
      end
      cursor_row_q = ROW_W'(SCREEN_ROWS - 1);
      return 1'b1;
    end
    cursor_row_q = cursor_row_q + 1'b1;
    return 1'b0;
  endfunction

  // apply one transaction to the screen image and return the report it causes
  function automatic result_t console_step(input op_e               op,
                                           input logic [CHAR_W-1:0] code,
                                           input logic [ROW_W-1:0]  rrow,
                                           input logic [COL_W-1:0]  rcol);
    result_t rep;
    rep = '0;
    if (op == OP_READ) begin
      if (rrow < SCREEN_ROWS && rcol < SCREEN_COLS) begin
        rep.read_char = screen_q[rrow][rcol];
      end
    end else if (code == CHAR_NEWLINE) begin
      rep.scrolled = line_feed();
    end else if (code != CHAR_NULL) begin
      // a pending wrap is taken before the character lands
      if (cursor_col_q >= SCREEN_COLS) begin
        rep.scrolled = line_feed();
      end
      screen_q[cursor_row_q][cursor_col_q] = code;
      cursor_col_q = cursor_col_q + 1'b1;
    end
    rep.cur_row = cursor_row_q;
    rep.cur_col = cursor_col_q;
    return rep;
  endfunction

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      fail_count_o++;
    end
  endtask

  // compare finished transactions first, then predict newly accepted ones
  always @(posedge clk_i or negedge rst_ni) begin : monitor
    result_t got;
    result_t want;
    if (!rst_ni) begin
      for (int r = 0; r < SCREEN_ROWS; r++) begin
        for (int c = 0; c < SCREEN_COLS; c++) begin
          screen_q[r][c] = CHAR_NULL;
        end
      end
      cursor_row_q = '0;
      cursor_col_q = '0;
      awaited_reports_q.delete();
      fail_count_o = 0;
      scroll_count_o = 0;
      outstanding_o <= 0;
    end else begin
      if (m_tvalid_i && m_tready_i) begin
        got.read_char = m_tdata_i[7:0];
        got.cur_row   = m_tdata_i[12:8];
        got.cur_col   = m_tdata_i[19:13];
        got.scrolled  = m_tdata_i[20];
        if (awaited_reports_q.size() == 0) begin
          $display("%0t ns: unexpected result, expected none, actual %h", $time, m_tdata_i);
          fail_count_o++;
        end else begin
          want = awaited_reports_q.pop_front();
          check_field("read_char", want.read_char, got.read_char);
          check_field("cur_row", want.cur_row, got.cur_row);
          check_field("cur_col", want.cur_col, got.cur_col);
          check_field("scrolled", want.scrolled, got.scrolled);
        end
      end
      if (s_tvalid_i && s_tready_i) begin
        want = console_step(op_e'(s_tuser_i), s_tdata_i[7:0], s_tdata_i[12:8],
                            s_tdata_i[19:13]);
        if (want.scrolled) begin
          scroll_count_o++;
        end
        awaited_reports_q.push_back(want);
      end
      outstanding_o <= awaited_reports_q.size();
    end
  end

endmodule

// File: verif/testbench.sv
// stimulus and verdict for the text console writer
`timescale 1ns / 1ps

module testbench;
  import tcw_pkg::*;

  localparam int TOTAL_ITEMS    = 1850;
  localparam int PHASE_ONE_AT   = 620;
  localparam int PHASE_TWO_AT   = 1240;
  localparam int DRAIN_AT       = 900;
  localparam int HOLDOFF_AT     = 1400;
  localparam int HOLDOFF_CYCLES = 400;
  localparam int SETTLE_CYCLES  = 120;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata;
  logic                  s_axis_tuser;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;

  int outstanding;
  int fail_count;
  int scroll_count;
  int sent_items;
  int put_count;
  int read_count;
  int newline_count;
  int null_count;
  logic holdoff_done;

  text_console_writer uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  tcw_checker console_check (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_tvalid_i     (s_axis_tvalid),
    .s_tready_i     (s_axis_tready),
    .s_tdata_i      (s_axis_tdata),
    .s_tuser_i      (s_axis_tuser),
    .m_tvalid_i     (m_axis_tvalid),
    .m_tready_i     (m_axis_tready),
    .m_tdata_i      (m_axis_tdata),
    .outstanding_o  (outstanding),
    .fail_count_o   (fail_count),
    .scroll_count_o (scroll_count)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    #20_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  // idling per phase: receiver-heavy, then sender-heavy, then none
  function automatic int sender_idle_pct();
    if (sent_items < PHASE_ONE_AT) return 14;
    if (sent_items < PHASE_TWO_AT) return 58;
    return 0;
  endfunction

  function automatic int receiver_idle_pct();
    if (sent_items < PHASE_ONE_AT) return 58;
    if (sent_items < PHASE_TWO_AT) return 14;
    return 0;
  endfunction

  // output side ready, with one long hold-off so the block backs up
  initial begin
    holdoff_done = 1'b0;
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (!holdoff_done && sent_items >= HOLDOFF_AT) begin
        holdoff_done = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (HOLDOFF_CYCLES) @(posedge clk_i);
      end else begin
        m_axis_tready <= ($urandom_range(99) >= receiver_idle_pct());
      end
    end
  end

  function automatic item_t put_item(input logic [CHAR_W-1:0] code);
    item_t it;
    it.opcode    = OP_PUT;
    it.char_code = code;
    it.read_row  = ROW_W'($urandom);
    it.read_col  = COL_W'($urandom);
    return it;
  endfunction

  function automatic item_t read_item(input int row, input int col);
    item_t it;
    it.opcode    = OP_READ;
    it.char_code = CHAR_W'($urandom);
    it.read_row  = ROW_W'(row);
    it.read_col  = COL_W'(col);
    return it;
  endfunction

  function automatic logic [CHAR_W-1:0] printable_code();
    logic [CHAR_W-1:0] c;
    c = CHAR_W'($urandom_range(1, 255));
    if (c == CHAR_NEWLINE) c = 8'h20;
    return c;
  endfunction

  // in-range cell, weighted towards the bottom rows where scrolling acts
  function automatic item_t cell_read();
    int row;
    row = ($urandom_range(1) == 1) ? $urandom_range(SCREEN_ROWS - 5, SCREEN_ROWS - 1)
                                   : $urandom_range(0, SCREEN_ROWS - 1);
    return read_item(row, $urandom_range(0, SCREEN_COLS - 1));
  endfunction

  // offer one transaction and wait for it to be taken
  task automatic send_item(input item_t it);
    while ($urandom_range(99) < sender_idle_pct()) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'b0, it.read_col, it.read_row, it.char_code};
    s_axis_tuser  <= it.opcode;
    do @(posedge clk_i); while (!s_axis_tready);
    sent_items++;
    if (it.opcode == OP_READ) begin
      read_count++;
    end else begin
      put_count++;
      if (it.char_code == CHAR_NEWLINE) newline_count++;
      if (it.char_code == CHAR_NULL) null_count++;
    end
    // one full drain in mid run
    if (sent_items == DRAIN_AT) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while (outstanding != 0);
    end
  endtask

  // one random stretch of console traffic
  task automatic send_burst();
    int kind;
    int n;
    item_t it;
    kind = $urandom_range(99);
    if (kind < 30) begin
      // full line from column 0, often reaching a pending wrap
      send_item(put_item(CHAR_NEWLINE));
      n = $urandom_range(76, 86);
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(9) == 0) send_item(cell_read());
        send_item(put_item(printable_code()));
      end
      if ($urandom_range(1) == 1) send_item(put_item(CHAR_NEWLINE));
    end else if (kind < 60) begin
      // short text with line breaks
      n = $urandom_range(5, 30);
      for (int i = 0; i < n; i++) begin
        case ($urandom_range(19))
          0, 1, 2: send_item(put_item(CHAR_NEWLINE));
          3, 4:    send_item(cell_read());
          default: send_item(put_item(printable_code()));
        endcase
      end
    end else if (kind < 80) begin
      // run of newlines to push through the bottom row
      n = $urandom_range(1, 30);
      for (int i = 0; i < n; i++) begin
        send_item(put_item(CHAR_NEWLINE));
        if ($urandom_range(2) == 0) send_item(put_item(printable_code()));
      end
    end else if (kind < 90) begin
      n = $urandom_range(5, 20);
      for (int i = 0; i < n; i++) begin
        send_item(cell_read());
      end
    end else begin
      // noise: any code, any address, out-of-range reads included
      n = $urandom_range(5, 15);
      for (int i = 0; i < n; i++) begin
        it.opcode    = op_e'($urandom_range(1));
        it.char_code = ($urandom_range(9) == 0) ? CHAR_NULL : CHAR_W'($urandom);
        it.read_row  = ROW_W'($urandom);
        it.read_col  = COL_W'($urandom);
        send_item(it);
      end
    end
  endtask

  // reset, directed cases, random traffic, drain and verdict
  initial begin
    sent_items    = 0;
    put_count     = 0;
    read_count    = 0;
    newline_count = 0;
    null_count    = 0;
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= OP_PUT;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // cleared screen, corners and out-of-range reads
    send_item(read_item(0, 0));
    send_item(read_item(SCREEN_ROWS - 1, SCREEN_COLS - 1));
    send_item(read_item(31, 127));
    send_item(read_item(SCREEN_ROWS, 0));
    send_item(read_item(0, SCREEN_COLS));
    // null leaves the cursor alone
    send_item(put_item(CHAR_NULL));
    send_item(put_item(8'hFF));
    send_item(put_item(8'h01));
    send_item(put_item(8'h80));
    send_item(put_item(CHAR_NULL));
    send_item(put_item(8'h7F));
    send_item(put_item(CHAR_NEWLINE));
    send_item(put_item(8'h41));
    send_item(put_item(CHAR_NEWLINE));
    send_item(put_item(CHAR_NEWLINE));
    send_item(read_item(0, 0));
    send_item(read_item(0, 1));
    send_item(read_item(0, 2));
    send_item(read_item(0, 3));
    send_item(read_item(1, 0));
    send_item(read_item(1, 1));
    send_item(read_item(2, 0));

    while (sent_items < TOTAL_ITEMS) begin
      send_burst();
    end
    s_axis_tvalid <= 1'b0;

    do @(posedge clk_i); while (outstanding != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("covered %0d transactions: %0d puts (%0d newlines, %0d nulls), %0d reads",
             sent_items, put_count, newline_count, null_count, read_count);
    $display("%0d screen scrolls, three idling phases, one output hold-off, one drain",
             scroll_count);
    if (fail_count == 0 && outstanding == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// File: text_console_writer.f
hw/rtl/tcw_pkg.sv
hw/rtl/tcw_screen_ram.sv
hw/rtl/tcw_ctrl.sv
hw/rtl/text_console_writer.sv
verif/tcw_checker.sv
verif/testbench.sv
